@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the id-addressed sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_by_id.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_SPACE = 16;
    localparam int ID_W     = 4;
    localparam int PRIO_W   = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int OUT_COUNT_W = 5;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_RAISE  = 3'd2,
        OP_LOWER  = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    // contents of one queue position
    typedef struct packed {
        logic                     valid;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } slot_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
`timescale 1ns / 1ps
// One position of the sorted queue: holds an entry, compares it with the
// broadcast priority and shifts towards either neighbour. Uses spq_pkg.
module spq_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  spq_pkg::cmd_t  cmd,
    input  spq_pkg::slot_t left_slot,
    input  logic           left_stays,
    input  spq_pkg::slot_t right_slot,
    input  logic           del_shift,
    output spq_pkg::slot_t slot,
    output logic           stays,
    output logic           match
);
    import spq_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    assign slot  = slot_reg;
    // entry keeps its place on insert only if strictly ahead of the new one
    assign stays = slot_reg.valid && (cmd.prio < slot_reg.prio);
    assign match = slot_reg.valid && (slot_reg.id == cmd.id);

    always_comb begin
        slot_next = slot_reg;
        if (cmd.ins) begin
            if (!stays) begin
                if (left_stays) begin
                    slot_next.valid = 1'b1;
                    slot_next.id    = cmd.id;
                    slot_next.prio  = cmd.prio;
                end else begin
                    slot_next = left_slot;
                end
            end
        end else if (cmd.del && del_shift) begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg.id   <= slot_next.id;
        slot_reg.prio <= slot_next.prio;
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
    end

endmodule

@@ hw/rtl/sorted_priority_queue_by_id.sv @@
`timescale 1ns / 1ps
// Top level of the id-addressed sorted priority queue: sequencer, id table
// and the row of spq_cell instances. Uses spq_pkg.
//
// Usage:
//   s_ channel carries one operation per beat: opcode (insert, remove head,
//   raise, lower, query), item_id and a signed Q16.16 priority_req.
//   m_ channel returns exactly one result beat per operation: ok, out_id,
//   out_priority and the entry count after the operation.
//   Entries sit in a row of cells, highest priority at cell 0; a new entry
//   lands ahead of equal priorities. Every cell compares the broadcast
//   priority and all cells shift left or right together.
//   Sequencing: an operation is taken while idle and executed in the
//   execute state; an accepted raise or lower pulls the entry out of the
//   row there and reinserts it in the following reinsert state.
//   The result lands in an output register; s_ready rises again as soon as
//   execution is done, even while that result is still waiting.
//   If the receiver stalls with a result pending, the next operation waits
//   in its execute step until the output register frees up.
//   Reset (aresetn low, synchronous) empties the queue and clears the id
//   table; no clearing pass is needed.
module sorted_priority_queue_by_id (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_opcode,
    input  logic [spq_pkg::ID_W-1:0]              s_item_id,
    input  logic signed [spq_pkg::PRIO_W-1:0]     s_priority_req,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_ok,
    output logic [spq_pkg::ID_W-1:0]              m_out_id,
    output logic signed [spq_pkg::PRIO_W-1:0]     m_out_priority,
    output logic [spq_pkg::OUT_COUNT_W-1:0]       m_count
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINS
    } state_t;

    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic [ID_W-1:0]           id_reg, id_next;
    logic signed [PRIO_W-1:0]  prio_reg, prio_next;
    logic [ID_SPACE-1:0]       present_reg, present_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_ok_reg, m_ok_next;
    logic [ID_W-1:0]           m_id_reg, m_id_next;
    logic signed [PRIO_W-1:0]  m_prio_reg, m_prio_next;
    logic [OUT_COUNT_W-1:0]    m_count_reg, m_count_next;

    cmd_t                      cmd;
    slot_t                     slots [CAPACITY];
    logic [CAPACITY-1:0]       stays;
    logic [CAPACITY-1:0]       match;
    logic [CAPACITY-1:0]       hit;
    logic [CAPACITY-1:0]       del_shift;
    logic signed [PRIO_W-1:0]  hit_prio;
    logic                      out_free;
    logic                      in_range;
    logic                      is_present;
    logic                      not_full;
    logic                      strict;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_out_id       = m_id_reg;
    assign m_out_priority = m_prio_reg;
    assign m_count        = m_count_reg;

    // row of cells
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        slot_t left_s, right_s;
        logic  left_st;
        if (k == 0) begin : g_first
            assign left_s  = '0;
            assign left_st = 1'b1;
        end else begin : g_mid
            assign left_s  = slots[k-1];
            assign left_st = stays[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_s = '0;
        end else begin : g_inner
            assign right_s = slots[k+1];
        end
        spq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .left_slot (left_s),
            .left_stays(left_st),
            .right_slot(right_s),
            .del_shift (del_shift[k]),
            .slot      (slots[k]),
            .stays     (stays[k]),
            .match     (match[k])
        );
    end

    // priority of the matching entry; ids are unique so at most one hits
    always_comb begin
        hit_prio = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            hit_prio = hit_prio | (match[k] ? slots[k].prio : '0);
        end
    end

    // every cell at or past the removed one takes its right neighbour
    always_comb begin
        logic run;
        run = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            run          = run | hit[k];
            del_shift[k] = run;
        end
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign in_range   = (32'(id_reg) < CAPACITY);
    assign is_present = in_range && present_reg[id_reg];
    assign not_full   = (count_reg < COUNT_W'(CAPACITY));
    assign strict     = (op_reg == OP_RAISE) ? (prio_reg > hit_prio)
                                             : (prio_reg < hit_prio);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        prio_next    = prio_reg;
        present_next = present_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_ok_next    = m_ok_reg;
        m_id_next    = m_id_reg;
        m_prio_next  = m_prio_reg;
        m_count_next = m_count_reg;
        cmd.ins      = 1'b0;
        cmd.del      = 1'b0;
        cmd.id       = id_reg;
        cmd.prio     = prio_reg;
        hit          = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = op_t'(s_opcode);
                    id_next    = s_item_id;
                    prio_next  = s_priority_req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    // default result: refused, current count
                    m_valid_next = 1'b1;
                    m_ok_next    = 1'b0;
                    m_id_next    = '0;
                    m_prio_next  = '0;
                    m_count_next = OUT_COUNT_W'(count_reg);
                    state_next   = S_IDLE;
                    case (op_reg)
                        OP_INSERT: begin
                            if (in_range && !present_reg[id_reg] && not_full) begin
                                cmd.ins              = 1'b1;
                                present_next[id_reg] = 1'b1;
                                count_next           = count_reg + 1'b1;
                                m_ok_next            = 1'b1;
                                m_count_next         = OUT_COUNT_W'(count_next);
                            end
                        end
                        OP_REMOVE: begin
                            if (count_reg != '0) begin
                                hit[0]                     = 1'b1;
                                cmd.del                    = 1'b1;
                                present_next[slots[0].id]  = 1'b0;
                                count_next                 = count_reg - 1'b1;
                                m_ok_next                  = 1'b1;
                                m_id_next                  = slots[0].id;
                                m_prio_next                = slots[0].prio;
                                m_count_next               = OUT_COUNT_W'(count_next);
                            end
                        end
                        OP_RAISE, OP_LOWER: begin
                            if (is_present && strict) begin
                                // pull it out now, reinsert next cycle
                                hit          = match;
                                cmd.del      = 1'b1;
                                count_next   = count_reg - 1'b1;
                                m_valid_next = m_valid_reg && !m_ready;
                                m_ok_next    = m_ok_reg;
                                m_id_next    = m_id_reg;
                                m_prio_next  = m_prio_reg;
                                m_count_next = m_count_reg;
                                state_next   = S_REINS;
                            end
                        end
                        OP_QUERY: begin
                            if (is_present) begin
                                m_ok_next   = 1'b1;
                                m_prio_next = hit_prio;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REINS: begin
                if (out_free) begin
                    cmd.ins      = 1'b1;
                    count_next   = count_reg + 1'b1;
                    m_valid_next = 1'b1;
                    m_ok_next    = 1'b1;
                    m_id_next    = '0;
                    m_prio_next  = '0;
                    m_count_next = OUT_COUNT_W'(count_next);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            present_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            present_reg <= present_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        id_reg      <= id_next;
        prio_reg    <= prio_next;
        m_ok_reg    <= m_ok_next;
        m_id_reg    <= m_id_next;
        m_prio_reg  <= m_prio_next;
        m_count_reg <= m_count_next;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_by_id: directed and random
// operations against a queue predictor. Depends on spq_pkg and the RTL.
module testbench;
    import spq_pkg::*;

    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [PRIO_W-1:0] PRIO_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic                     ok;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic [OUT_COUNT_W-1:0]   count;
    } queue_result_t;

    typedef enum {DRAIN_FREE, DRAIN_PATTERN, DRAIN_SPARSE} drain_mode_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [2:0]               s_opcode = '0;
    logic [ID_W-1:0]          s_item_id = '0;
    logic signed [PRIO_W-1:0] s_priority_req = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_ok;
    logic [ID_W-1:0]          m_out_id;
    logic signed [PRIO_W-1:0] m_out_priority;
    logic [OUT_COUNT_W-1:0]   m_count;

    // predicted queue contents, head at index 0
    logic [ID_W-1:0]          row_id [CAPACITY];
    logic signed [PRIO_W-1:0] row_prio [CAPACITY];
    bit                       id_held [ID_SPACE];
    int                       held = 0;

    queue_result_t            queue_results_due[$];
    int                       mismatches = 0;
    int                       beats_seen = 0;
    int                       burst_left = 0;
    bit                       gaps_on = 1'b1;

    sorted_priority_queue_by_id uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_item_id      (s_item_id),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_out_id       (m_out_id),
        .m_out_priority (m_out_priority),
        .m_count        (m_count)
    );

    always #1 aclk = ~aclk;

    // ---- queue predictor ----

    function automatic void take_out(input int k);
        int j;
        for (j = k; j + 1 < held; j++) begin
            row_id[j]   = row_id[j + 1];
            row_prio[j] = row_prio[j + 1];
        end
        held--;
    endfunction

    // new entry goes ahead of equal priorities
    function automatic void place_sorted(input logic [ID_W-1:0] id,
                                         input logic signed [PRIO_W-1:0] prio);
        int pos;
        int j;
        pos = 0;
        while (pos < held && prio < row_prio[pos])
            pos++;
        for (j = held; j > pos; j--) begin
            row_id[j]   = row_id[j - 1];
            row_prio[j] = row_prio[j - 1];
        end
        row_id[pos]   = id;
        row_prio[pos] = prio;
        held++;
    endfunction

    function automatic int slot_of(input logic [ID_W-1:0] id);
        int k;
        for (k = 0; k < held; k++)
            if (row_id[k] == id)
                return k;
        return held;
    endfunction

    function automatic queue_result_t queue_op_result(input logic [2:0] op,
            input logic [ID_W-1:0] id, input logic signed [PRIO_W-1:0] prio);
        queue_result_t r;
        int k;
        bit known;
        r = '0;
        known = int'(id) < CAPACITY && id_held[id];
        case (op)
            OP_INSERT: if (int'(id) < CAPACITY && !id_held[id] && held < CAPACITY) begin
                place_sorted(id, prio);
                id_held[id] = 1'b1;
                r.ok = 1'b1;
            end
            OP_REMOVE: if (held > 0) begin
                r.ok   = 1'b1;
                r.id   = row_id[0];
                r.prio = row_prio[0];
                id_held[row_id[0]] = 1'b0;
                take_out(0);
            end
            OP_RAISE, OP_LOWER: if (known) begin
                k = slot_of(id);
                if ((op == OP_RAISE) ? (prio > row_prio[k]) : (prio < row_prio[k])) begin
                    take_out(k);
                    place_sorted(id, prio);
                    r.ok = 1'b1;
                end
            end
            OP_QUERY: if (known) begin
                r.ok   = 1'b1;
                r.prio = row_prio[slot_of(id)];
            end
            default: ;
        endcase
        r.count = held[OUT_COUNT_W-1:0];
        return r;
    endfunction

    // ---- stimulus helpers ----

    function automatic logic signed [PRIO_W-1:0] pick_prio(input bit tie_heavy);
        int sel;
        sel = $urandom_range(0, 7);
        if (tie_heavy && sel < 5)
            return (int'($urandom_range(0, 4)) - 2) * 65536;
        if (sel == 7) begin
            case ($urandom_range(0, 3))
                0: return PRIO_MAX;
                1: return PRIO_MIN;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // strictly above or below old unless old already sits at that rail; saturates at the rails
    function automatic logic signed [PRIO_W-1:0] moved_prio(
            input logic signed [PRIO_W-1:0] old, input bit up);
        longint t;
        longint step;
        step = longint'($urandom_range(1, 1 << 18));
        t = up ? longint'(old) + step : longint'(old) - step;
        if (t > longint'(PRIO_MAX)) t = longint'(PRIO_MAX);
        if (t < longint'(PRIO_MIN)) t = longint'(PRIO_MIN);
        return t[PRIO_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] free_id();
        int start;
        int i;
        start = $urandom_range(0, ID_SPACE - 1);
        for (i = 0; i < ID_SPACE; i++)
            if (!id_held[(start + i) % ID_SPACE])
                return ID_W'((start + i) % ID_SPACE);
        return ID_W'(start);
    endfunction

    function automatic logic [ID_W-1:0] held_id();
        if (held == 0)
            return ID_W'($urandom_range(0, ID_SPACE - 1));
        return row_id[$urandom_range(0, held - 1)];
    endfunction

    task automatic send_op(input logic [2:0] op, input logic [ID_W-1:0] id,
                           input logic signed [PRIO_W-1:0] prio);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on)
                gap = $urandom_range(0, 6);
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_item_id      <= id;
        s_priority_req <= prio;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        queue_results_due.push_back(queue_op_result(op, id, prio));
    endtask

    // ---- tests ----

    task automatic test_directed();
        send_op(OP_REMOVE, 4'd0, '0);            // empty queue
        send_op(OP_QUERY,  4'd3, '0);
        send_op(OP_RAISE,  4'd3, PRIO_MAX);
        send_op(OP_INSERT, 4'd0, PRIO_MAX);
        send_op(OP_INSERT, 4'd15, PRIO_MIN);
        send_op(OP_INSERT, 4'd7, '0);
        send_op(OP_INSERT, 4'd8, '0);            // tie: lands ahead of id 7
        send_op(OP_INSERT, 4'd7, PRIO_ONE);      // duplicate
        send_op(OP_QUERY,  4'd15, '0);
        send_op(OP_RAISE,  4'd8, '0);            // same priority, refused
        send_op(OP_RAISE,  4'd15, 32'sh0001_8000);
        send_op(OP_LOWER,  4'd0, PRIO_MAX);      // same priority, refused
        send_op(OP_LOWER,  4'd0, -1);
        send_op(OP_RAISE,  4'd15, PRIO_MAX);
        send_op(OP_LOWER,  4'd8, PRIO_ONE);      // higher, refused
        send_op(OP_UNDEF_LO, 4'd15, PRIO_MAX);
        send_op(OP_UNDEF_HI, 4'd15, -1);
        send_op(OP_QUERY,  4'd0, '0);
        send_op(OP_REMOVE, 4'd9, '0);
        send_op(OP_LOWER,  4'd7, PRIO_MIN);
        repeat (5) send_op(OP_REMOVE, 4'd15, PRIO_MAX);
    endtask

    // fill every id, try one more, then empty it again
    task automatic test_fill_drain(input int rounds);
        int r;
        bit ties;
        for (r = 0; r < rounds; r++) begin
            ties = r[0];
            gaps_on = (r % 3 != 2);
            while (held < CAPACITY)
                send_op(OP_INSERT, free_id(), pick_prio(ties));
            send_op(OP_INSERT, ID_W'($urandom_range(0, ID_SPACE - 1)), pick_prio(ties));
            if (r % 2 == 0)
                send_op(OP_QUERY, held_id(), '0);
            while (held > 0)
                send_op(OP_REMOVE, ID_W'($urandom_range(0, ID_SPACE - 1)), $urandom);
            send_op(OP_REMOVE, ID_W'($urandom_range(0, ID_SPACE - 1)), $urandom);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_mixed_ops(input int n);
        int i;
        int w;
        int k;
        bit fill_bias;
        bit ties;
        bit up;
        logic [ID_W-1:0] id;
        logic signed [PRIO_W-1:0] p;
        fill_bias = 1'b1;
        ties = 1'b0;
        for (i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                fill_bias = ~fill_bias;
                ties = 1'($urandom_range(0, 1));
                gaps_on = (i % 300 != 200);
            end
            w = $urandom_range(0, 99);
            if (w < (fill_bias ? 45 : 20)) begin
                id = ($urandom_range(0, 4) != 0) ? free_id() : held_id();
                send_op(OP_INSERT, id, pick_prio(ties));
            end else if (w < 60) begin
                send_op(OP_REMOVE, ID_W'($urandom_range(0, ID_SPACE - 1)), $urandom);
            end else if (w < 88) begin
                up = (w < 74);
                id = ($urandom_range(0, 4) != 0) ? held_id()
                                                 : ID_W'($urandom_range(0, ID_SPACE - 1));
                p = pick_prio(ties);
                k = slot_of(id);
                if (k < held && $urandom_range(0, 3) != 0 &&
                        !(up ? p > row_prio[k] : p < row_prio[k]))
                    p = moved_prio(row_prio[k], up);
                else if (k < held && $urandom_range(0, 9) == 0)
                    p = row_prio[k];
                send_op(up ? OP_RAISE : OP_LOWER, id, p);
            end else if (w < 97) begin
                id = ($urandom_range(0, 3) != 0) ? held_id()
                                                 : ID_W'($urandom_range(0, ID_SPACE - 1));
                send_op(OP_QUERY, id, $urandom);
            end else begin
                send_op(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)),
                        ID_W'($urandom_range(0, ID_SPACE - 1)), $urandom);
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_noise(input int n);
        int i;
        gaps_on = 1'b0;
        for (i = 0; i < n; i++)
            send_op(3'($urandom_range(0, 7)), ID_W'($urandom_range(0, ID_SPACE - 1)),
                    $urandom);
        gaps_on = 1'b1;
    endtask

    // ---- result side ----

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch, result beat %0d: %s", $realtime, beats_seen, what);
    endtask

    // receiver back-pressure in one of three drain modes, picked anew at random
    drain_mode_t drain_mode = DRAIN_FREE;
    logic [15:0] drain_pattern = 16'hFFFF;
    int          drain_cycle = 0;

    always @(posedge aclk) begin
        drain_cycle++;
        if (drain_cycle % 300 == 0) begin
            drain_mode    = drain_mode_t'($urandom_range(0, 2));
            drain_pattern = 16'($urandom) | 16'h0001;
        end
        case (drain_mode)
            DRAIN_FREE:    m_ready <= 1'b1;
            DRAIN_PATTERN: m_ready <= drain_pattern[4'(drain_cycle % 16)];
            default:       m_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (queue_results_due.size() == 0) begin
                flag_mismatch("result beat with nothing outstanding");
            end else begin
                want = queue_results_due.pop_front();
                if (m_ok !== want.ok)
                    flag_mismatch($sformatf("ok %0b, want %0b", m_ok, want.ok));
                if (m_out_id !== want.id)
                    flag_mismatch($sformatf("out_id %0d, want %0d", m_out_id, want.id));
                if (m_out_priority !== want.prio)
                    flag_mismatch($sformatf("out_priority %h, want %h",
                                            m_out_priority, want.prio));
                if (m_count !== want.count)
                    flag_mismatch($sformatf("count %0d, want %0d", m_count, want.count));
            end
            beats_seen++;
        end
    end

    initial begin
        #1_000_000;
        $display("sorted_priority_queue_by_id regression: fail");
        $finish;
    end

    initial begin
        int waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill_drain(10);
        test_mixed_ops(800);
        test_noise(150);
        s_valid <= 1'b0;

        waited = 0;
        while (queue_results_due.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (queue_results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", queue_results_due.size()));
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("sorted_priority_queue_by_id regression: pass");
        else
            $display("sorted_priority_queue_by_id regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_by_id.sv
tb/testbench.sv
